// File: rtl/tiny_language_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// tiny language tokenizer assertion macros
// shared property forms for the checker of the tokenizer
// ----------------------------------------------------------------------------
`ifndef TINY_LANGUAGE_TOKENIZER_DEFINES_SVH
`define TINY_LANGUAGE_TOKENIZER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define TLT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define TLT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// types, codes, character tables and helpers of the tiny language tokenizer
// ----------------------------------------------------------------------------
package tlt_pkg;

   // scan modes
   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_NUM     = 2'd1,
      MODE_ID      = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   // token kinds
   typedef enum logic [2:0] {
      KIND_NUM      = 3'd0,
      KIND_ID       = 3'd1,
      KIND_SPECIAL  = 3'd2,
      KIND_RESERVED = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   localparam int NUM_SYMS  = 10;
   localparam int NUM_WORDS = 8;
   localparam int WIN_LEN   = 6;

   // symbol codes
   localparam logic [4:0] SYM_NONE      = 5'd0;
   localparam logic [4:0] SYM_ASSIGN    = 5'd10;
   localparam logic [4:0] SYM_WORD_BASE = 5'd11;
   localparam logic [4:0] SYM_WORD_LAST = 5'd18;

   // fixed characters
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_RBRACE = "}";
   localparam logic [7:0] CH_COLON  = ":";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_NUL    = 8'h00;

   // single-character symbols, in code order
   localparam logic [7:0] SINGLE_SYMS [NUM_SYMS] = '{
      "+", "-", "/", "*", ";", "=", "<", ">", "(", ")"
   };

   // reserved words, padded with nul
   localparam logic [7:0] WORD_CHARS [NUM_WORDS][WIN_LEN] = '{
      '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"t", "h", "e", "n", CH_NUL, CH_NUL},
      '{"e", "l", "s", "e", CH_NUL, CH_NUL},
      '{"r", "e", "a", "d", CH_NUL, CH_NUL},
      '{"e", "n", "d", CH_NUL, CH_NUL, CH_NUL},
      '{"r", "e", "p", "e", "a", "t"},
      '{"u", "n", "t", "i", "l", CH_NUL},
      '{"w", "r", "i", "t", "e", CH_NUL}
   };

   localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
      3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd5
   };

   // current character at index 0, lookahead after it
   typedef logic [WIN_LEN-1:0][7:0] window_type;

   // one result item
   typedef struct packed {
      kind_type   kind;
      logic [4:0] symbol;
      logic [7:0] bad_char;
   } token_type;

   // character classes
   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic id_cont(input logic [7:0] c);
      return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
   endfunction

endpackage

// File: rtl/tlt_ifs.sv
// ----------------------------------------------------------------------------
// tlt channel interfaces
// valid/ready channels for character windows and tokens
// ----------------------------------------------------------------------------

// character window channel
interface tlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic [7:0] next1;
   logic [7:0] next2;
   logic [7:0] next3;
   logic [7:0] next4;
   logic [7:0] next5;

   modport source (output valid, ch, next1, next2, next3, next4, next5, input ready);
   modport sink   (input valid, ch, next1, next2, next3, next4, next5, output ready);
endinterface

// token channel
interface tlt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [4:0] symbol;
   logic [7:0] bad_char;

   modport source (output valid, kind, symbol, bad_char, input ready);
   modport sink   (input valid, kind, symbol, bad_char, output ready);
endinterface

// File: rtl/tlt_in_reg.sv
// ----------------------------------------------------------------------------
// tlt_in_reg
// input register: holds one character window until the scanner takes it
// ----------------------------------------------------------------------------
module tlt_in_reg (
   input  logic                clock,
   input  logic                reset,
   tlt_req_if.sink             req,
   input  logic                advance,
   output logic                win_valid,
   output tlt_pkg::window_type win
);

   logic                valid_ff;
   logic                valid_in;
   tlt_pkg::window_type win_ff;
   logic                accept;

   // take a new item when empty or when the held one moves on
   assign req.ready = !valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= req.ch;
         win_ff[1] <= req.next1;
         win_ff[2] <= req.next2;
         win_ff[3] <= req.next3;
         win_ff[4] <= req.next4;
         win_ff[5] <= req.next5;
      end
   end

   assign win_valid = valid_ff;
   assign win       = win_ff;

endmodule

// File: rtl/tlt_scan_core.sv
// ----------------------------------------------------------------------------
// tlt_scan_core
// scan mode and skip count, and the per-character token decision
// ----------------------------------------------------------------------------
module tlt_scan_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tlt_pkg::window_type win,
   output logic                tok_valid,
   output tlt_pkg::token_type  tok
);

   tlt_pkg::mode_type mode_ff;
   tlt_pkg::mode_type mode_in;
   logic [2:0]        skip_ff;
   logic [2:0]        skip_in;

   logic [7:0] x;
   logic [7:0] n1;
   logic       sym_hit;
   logic [3:0] sym_idx;
   logic       word_hit;
   logic [2:0] word_idx;

   assign x  = win[0];
   assign n1 = win[1];

   // symbol and reserved word lookup
   always_comb begin
      logic hit;
      sym_hit  = 1'b0;
      sym_idx  = 4'd0;
      word_hit = 1'b0;
      word_idx = 3'd0;
      for (int i = tlt_pkg::NUM_SYMS - 1; i >= 0; i--) begin
         if (x == tlt_pkg::SINGLE_SYMS[i]) begin
            sym_hit = 1'b1;
            sym_idx = 4'(i);
         end
      end
      // lowest matching word wins
      for (int w = tlt_pkg::NUM_WORDS - 1; w >= 0; w--) begin
         hit = 1'b1;
         for (int k = 0; k < tlt_pkg::WIN_LEN; k++) begin
            if ((3'(k) < tlt_pkg::WORD_LEN[w]) && (win[k] != tlt_pkg::WORD_CHARS[w][k])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            word_hit = 1'b1;
            word_idx = 3'(w);
         end
      end
   end

   // next scan mode and skip count
   always_comb begin
      mode_in = mode_ff;
      skip_in = skip_ff;
      if (skip_ff != 3'd0) begin
         skip_in = skip_ff - 3'd1;
         mode_in = tlt_pkg::MODE_START;
      end else if ((x == tlt_pkg::CH_SPACE) && (mode_ff != tlt_pkg::MODE_COMMENT)) begin
         mode_in = tlt_pkg::MODE_START;
      end else if (x == tlt_pkg::CH_LBRACE) begin
         mode_in = tlt_pkg::MODE_COMMENT;
      end else begin
         case (mode_ff)
            tlt_pkg::MODE_COMMENT: begin
               if (x == tlt_pkg::CH_RBRACE) begin
                  mode_in = tlt_pkg::MODE_START;
               end
            end
            tlt_pkg::MODE_NUM: begin
               if (!tlt_pkg::is_digit(n1)) begin
                  mode_in = tlt_pkg::MODE_START;
               end
            end
            tlt_pkg::MODE_ID: begin
               if (!tlt_pkg::id_cont(n1)) begin
                  mode_in = tlt_pkg::MODE_START;
               end
            end
            tlt_pkg::MODE_START: begin
               if (tlt_pkg::is_digit(x)) begin
                  if (tlt_pkg::is_digit(n1)) begin
                     mode_in = tlt_pkg::MODE_NUM;
                  end
               end else if (sym_hit) begin
                  mode_in = tlt_pkg::MODE_START;
               end else if (x == tlt_pkg::CH_COLON) begin
                  if (n1 == tlt_pkg::CH_EQUAL) begin
                     skip_in = 3'd1;
                  end
               end else if (tlt_pkg::is_alpha(x) || (x == tlt_pkg::CH_UNDER)) begin
                  if (word_hit) begin
                     skip_in = tlt_pkg::WORD_LEN[word_idx] - 3'd1;
                  end else if (tlt_pkg::id_cont(n1)) begin
                     mode_in = tlt_pkg::MODE_ID;
                  end
               end
            end
            default: begin
               mode_in = tlt_pkg::MODE_START;
            end
         endcase
      end
   end

   // token for this character
   always_comb begin
      tok_valid    = 1'b0;
      tok.kind     = tlt_pkg::KIND_NUM;
      tok.symbol   = tlt_pkg::SYM_NONE;
      tok.bad_char = 8'h00;
      if (skip_ff != 3'd0) begin
         tok_valid = 1'b0;
      end else if ((x == tlt_pkg::CH_SPACE) && (mode_ff != tlt_pkg::MODE_COMMENT)) begin
         tok_valid = 1'b0;
      end else if (x == tlt_pkg::CH_LBRACE) begin
         tok_valid = 1'b0;
      end else begin
         case (mode_ff)
            tlt_pkg::MODE_COMMENT: begin
               tok_valid = 1'b0;
            end
            tlt_pkg::MODE_NUM: begin
               tok_valid = !tlt_pkg::is_digit(n1);
               tok.kind  = tlt_pkg::KIND_NUM;
            end
            tlt_pkg::MODE_ID: begin
               tok_valid = !tlt_pkg::id_cont(n1);
               tok.kind  = tlt_pkg::KIND_ID;
            end
            tlt_pkg::MODE_START: begin
               if (tlt_pkg::is_digit(x)) begin
                  tok_valid = !tlt_pkg::is_digit(n1);
                  tok.kind  = tlt_pkg::KIND_NUM;
               end else if (sym_hit) begin
                  tok_valid  = 1'b1;
                  tok.kind   = tlt_pkg::KIND_SPECIAL;
                  tok.symbol = {1'b0, sym_idx};
               end else if (x == tlt_pkg::CH_COLON) begin
                  tok_valid = 1'b1;
                  if (n1 == tlt_pkg::CH_EQUAL) begin
                     tok.kind   = tlt_pkg::KIND_SPECIAL;
                     tok.symbol = tlt_pkg::SYM_ASSIGN;
                  end else begin
                     tok.kind     = tlt_pkg::KIND_ERROR;
                     tok.bad_char = x;
                  end
               end else if (tlt_pkg::is_alpha(x) || (x == tlt_pkg::CH_UNDER)) begin
                  if (word_hit) begin
                     tok_valid  = 1'b1;
                     tok.kind   = tlt_pkg::KIND_RESERVED;
                     tok.symbol = tlt_pkg::SYM_WORD_BASE + {2'b00, word_idx};
                  end else begin
                     tok_valid = !tlt_pkg::id_cont(n1);
                     tok.kind  = tlt_pkg::KIND_ID;
                  end
               end else begin
                  tok_valid    = 1'b1;
                  tok.kind     = tlt_pkg::KIND_ERROR;
                  tok.bad_char = x;
               end
            end
            default: begin
               tok_valid = 1'b0;
            end
         endcase
      end
   end

   // state registers, updated once per consumed character
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tlt_pkg::MODE_START;
         skip_ff <= 3'd0;
      end else if (step) begin
         mode_ff <= mode_in;
         skip_ff <= skip_in;
      end
   end

endmodule

// File: rtl/tlt_out_reg.sv
// ----------------------------------------------------------------------------
// tlt_out_reg
// result register: holds one token until the consumer takes it
// ----------------------------------------------------------------------------
module tlt_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               tok_valid,
   input  tlt_pkg::token_type tok,
   output logic               can_load,
   tlt_rsp_if.source          rsp
);

   logic               valid_ff;
   logic               valid_in;
   tlt_pkg::token_type tok_ff;
   logic               fill;

   // free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp.ready;
   assign fill     = load && tok_valid;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill) begin
         tok_ff <= tok;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.kind     = tok_ff.kind;
   assign rsp.symbol   = tok_ff.symbol;
   assign rsp.bad_char = tok_ff.bad_char;

endmodule

// File: rtl/tiny_language_tokenizer.sv
// a character is held in the input register, scanned combinationally, and its token held in the result register
// throughput: one character per cycle while the result side has room, set by the single scan step between the registers
// a stalled result register holds the scanner and the input register until it drains
// reset (synchronous, active high): scan mode to start, skip count to zero, both stages empty
// ----------------------------------------------------------------------------
// tiny_language_tokenizer
// character-at-a-time lexer with five characters of lookahead
// ----------------------------------------------------------------------------
module tiny_language_tokenizer (
   input  logic      clock,
   input  logic      reset,
   tlt_req_if.sink   req,
   tlt_rsp_if.source rsp
);

   logic                win_valid;
   tlt_pkg::window_type win;
   logic                tok_valid;
   tlt_pkg::token_type  tok;
   logic                can_load;
   logic                advance;

   // one character moves through the scan step when the result side has room
   assign advance = win_valid && can_load;

   tlt_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .advance   (advance),
      .win_valid (win_valid),
      .win       (win)
   );

   tlt_scan_core u_scan_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .win       (win),
      .tok_valid (tok_valid),
      .tok       (tok)
   );

   tlt_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .tok_valid (tok_valid),
      .tok       (tok),
      .can_load  (can_load),
      .rsp       (rsp)
   );

endmodule

// File: rtl/tlt_checker.sv
// ----------------------------------------------------------------------------
// tlt_checker
// port-level checks on the tokens leaving the tokenizer
// ----------------------------------------------------------------------------
`include "tiny_language_tokenizer_defines.svh"

module tlt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [4:0] rsp_symbol,
   input logic [7:0] rsp_bad_char
);

   logic        rsp_stall;
   logic [16:0] rsp_word;
   logic        kind_ok;
   logic        not_err;
   logic        bad_zero;
   logic        is_word;
   logic        word_ok;
   logic        plain_tok;
   logic        sym_zero;

   // terms of the checks
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_valid, rsp_kind, rsp_symbol, rsp_bad_char};
   assign kind_ok   = (rsp_kind <= tlt_pkg::KIND_ERROR);
   assign not_err   = rsp_valid && (rsp_kind != tlt_pkg::KIND_ERROR);
   assign bad_zero  = (rsp_bad_char == 8'h00);
   assign is_word   = rsp_valid && (rsp_kind == tlt_pkg::KIND_RESERVED);
   assign word_ok   = (rsp_symbol >= tlt_pkg::SYM_WORD_BASE) &&
                      (rsp_symbol <= tlt_pkg::SYM_WORD_LAST);
   assign plain_tok = rsp_valid && ((rsp_kind == tlt_pkg::KIND_NUM) ||
                                    (rsp_kind == tlt_pkg::KIND_ID) ||
                                    (rsp_kind == tlt_pkg::KIND_ERROR));
   assign sym_zero  = (rsp_symbol == tlt_pkg::SYM_NONE);

   // a stalled token holds its value
   `TLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "stalled token changed")

   // kind is one of the five token kinds
   `TLT_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, kind_ok, "illegal token kind")

   // only an error token carries a character
   `TLT_ASSERT_IMPLY(a_bad_zero, clock, reset, not_err, bad_zero, "bad_char on non-error token")

   // reserved word codes stay in their range
   `TLT_ASSERT_IMPLY(a_word_code, clock, reset, is_word, word_ok, "word code out of range")

   // symbol is zero for number, identifier and error tokens
   `TLT_ASSERT_IMPLY(a_symbol_zero, clock, reset, plain_tok, sym_zero, "symbol set on plain token")

endmodule

bind tiny_language_tokenizer tlt_checker u_tlt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_kind     (rsp.kind),
   .rsp_symbol   (rsp.symbol),
   .rsp_bad_char (rsp.bad_char)
);
